// ===== src/uhbdp_pkg.sv =====
// shared types and constants for the usb hid boot descriptor parser
package uhbdp_pkg;

    // default cap on the number of kept block bytes
    localparam int unsigned DEFAULT_MAX_BLOCK_BYTES = 256;

    // block layout
    localparam int unsigned HEADER_CFG_POS  = 5;
    localparam int unsigned MIN_BLOCK_BYTES = 9;
    localparam int unsigned FIELD_DEPTH     = 8;

    // descriptor codes
    localparam logic [7:0] DESC_TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] INTF_MIN_LEN        = 8'd9;
    localparam logic [7:0] EP_MIN_LEN          = 8'd7;
    localparam logic [7:0] CLASS_HID           = 8'd3;
    localparam logic [7:0] SUBCLASS_BOOT       = 8'd1;
    localparam logic [7:0] PROTOCOL_KEYBOARD   = 8'd1;
    localparam logic [7:0] PROTOCOL_MOUSE      = 8'd2;
    localparam logic [7:0] EP_DIR_IN           = 8'h80;
    localparam logic [7:0] EP_XFER_MASK        = 8'h03;
    localparam logic [7:0] EP_XFER_INTERRUPT   = 8'h03;

    // result status codes
    typedef enum logic [1:0] {
        ST_MOUSE        = 2'd0,
        ST_KEYBOARD     = 2'd1,
        ST_HID_NOT_BOOT = 2'd2,
        ST_NO_BOOT      = 2'd3
    } t_status;

    // active boot interface
    typedef enum logic [1:0] {
        PROTO_NONE     = 2'd0,
        PROTO_KEYBOARD = 2'd1,
        PROTO_MOUSE    = 2'd2
    } t_proto;

    // recorded interrupt in endpoint
    typedef struct packed {
        logic [7:0]  addr;
        logic [15:0] max_packet;
        logic [7:0]  interval;
        logic        valid;
    } t_ep_rec;

    // one parse result
    typedef struct packed {
        t_status     status;
        logic [7:0]  config_id;
        logic [7:0]  intf_num;
        logic [7:0]  endpoint_address;
        logic [15:0] endpoint_max_packet;
        logic [7:0]  endpoint_interval;
    } t_result;

endpackage

// ===== src/uhbdp_in_if.sv =====
// byte stream channel into the parser
interface uhbdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/uhbdp_out_if.sv =====
// result channel out of the parser
interface uhbdp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  config_id;
    logic [7:0]  intf_num;
    logic [7:0]  endpoint_address;
    logic [15:0] endpoint_max_packet;
    logic [7:0]  endpoint_interval;

    modport source (
        output valid, output status, output config_id, output intf_num,
        output endpoint_address, output endpoint_max_packet, output endpoint_interval,
        input ready
    );
    modport sink (
        input valid, input status, input config_id, input intf_num,
        input endpoint_address, input endpoint_max_packet, input endpoint_interval,
        output ready
    );
endinterface

// ===== src/uhbdp_core.sv =====
// descriptor chain walker state and per-byte update
module uhbdp_core #(
    parameter int unsigned MAX_BLOCK_BYTES = uhbdp_pkg::DEFAULT_MAX_BLOCK_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output uhbdp_pkg::t_result o_result
);
    import uhbdp_pkg::*;

    localparam int unsigned POS_W = ($clog2(MAX_BLOCK_BYTES + 1) > 8) ?
                                    $clog2(MAX_BLOCK_BYTES + 1) : 9;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_nds, n_nds;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_fields [FIELD_DEPTH];
    logic [7:0]       n_fields [FIELD_DEPTH];
    logic             r_stopped, n_stopped;
    t_proto           r_proto, n_proto;
    logic             r_last_hid, n_last_hid;
    logic             r_any_intf, n_any_intf;
    logic [7:0]       r_cfg, n_cfg;
    logic             r_mouse_found, n_mouse_found;
    logic             r_kb_found, n_kb_found;
    logic [7:0]       r_mouse_intf, n_mouse_intf;
    logic [7:0]       r_kb_intf, n_kb_intf;
    t_ep_rec          r_mouse_ep, n_mouse_ep;
    t_ep_rec          r_kb_ep, n_kb_ep;

    // state after taking the current byte
    always_comb begin
        logic [POS_W-1:0] off;
        t_ep_rec          ep;
        off           = '0;
        ep            = '0;
        n_pos         = r_pos;
        n_nds         = r_nds;
        n_len         = r_len;
        n_type        = r_type;
        n_fields      = r_fields;
        n_stopped     = r_stopped;
        n_proto       = r_proto;
        n_last_hid    = r_last_hid;
        n_any_intf    = r_any_intf;
        n_cfg         = r_cfg;
        n_mouse_found = r_mouse_found;
        n_kb_found    = r_kb_found;
        n_mouse_intf  = r_mouse_intf;
        n_kb_intf     = r_kb_intf;
        n_mouse_ep    = r_mouse_ep;
        n_kb_ep       = r_kb_ep;
        if (r_pos < POS_W'(MAX_BLOCK_BYTES)) begin
            n_pos = POS_W'(r_pos + 1'b1);
            if (r_pos == POS_W'(HEADER_CFG_POS)) begin
                n_cfg = i_byte;
            end
            if (!r_stopped) begin
                if (r_pos == '0) begin
                    // header length sets where the chain begins
                    if (i_byte == 8'd0) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_nds = POS_W'(i_byte);
                    end
                end else if (r_pos == r_nds) begin
                    // length byte of a new descriptor
                    if (i_byte == 8'd0) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_len = i_byte;
                        n_type = 8'd0;
                        for (int k = 0; k < FIELD_DEPTH; k++) begin
                            n_fields[k] = 8'd0;
                        end
                        n_fields[0] = i_byte;
                        if (i_byte == 8'd1) begin
                            n_nds = POS_W'(r_pos + 1'b1);
                        end
                    end
                end else if (r_pos > r_nds) begin
                    // body byte of the current descriptor
                    off = POS_W'(r_pos - r_nds);
                    if (off < POS_W'(FIELD_DEPTH)) begin
                        n_fields[off[2:0]] = i_byte;
                    end
                    if (off == POS_W'(1)) begin
                        n_type = i_byte;
                    end
                    if ((POS_W+1)'(off) + 1'b1 >= (POS_W+1)'(r_len)) begin
                        n_nds = POS_W'(r_pos + 1'b1);
                        // completed interface descriptor
                        if (n_type == DESC_TYPE_INTERFACE && r_len >= INTF_MIN_LEN) begin
                            n_any_intf = 1'b1;
                            n_last_hid = (n_fields[5] == CLASS_HID);
                            if (n_fields[5] == CLASS_HID && n_fields[6] == SUBCLASS_BOOT &&
                                n_fields[7] == PROTOCOL_MOUSE) begin
                                n_mouse_found = 1'b1;
                                n_proto       = PROTO_MOUSE;
                                n_mouse_intf  = n_fields[2];
                            end else if (n_fields[5] == CLASS_HID &&
                                         n_fields[6] == SUBCLASS_BOOT &&
                                         n_fields[7] == PROTOCOL_KEYBOARD) begin
                                n_kb_found = 1'b1;
                                n_proto    = PROTO_KEYBOARD;
                                n_kb_intf  = n_fields[2];
                            end else begin
                                n_proto = PROTO_NONE;
                            end
                        end
                        // completed interrupt in endpoint under a boot interface
                        if (n_type == DESC_TYPE_ENDPOINT && r_len >= EP_MIN_LEN &&
                            r_proto != PROTO_NONE &&
                            (n_fields[2] & EP_DIR_IN) != 8'd0 &&
                            (n_fields[3] & EP_XFER_MASK) == EP_XFER_INTERRUPT) begin
                            ep.addr       = n_fields[2];
                            ep.max_packet = {n_fields[5], n_fields[4]};
                            ep.interval   = n_fields[6];
                            ep.valid      = 1'b1;
                            if (r_proto == PROTO_MOUSE) begin
                                n_mouse_ep = ep;
                            end else if (r_proto == PROTO_KEYBOARD) begin
                                n_kb_ep = ep;
                            end
                        end
                    end
                end
            end
        end
    end

    // result selection from the updated state
    always_comb begin
        o_result = '0;
        if (n_pos < POS_W'(MIN_BLOCK_BYTES)) begin
            o_result.status = ST_NO_BOOT;
        end else if (n_mouse_found && n_mouse_ep.valid) begin
            o_result.status              = ST_MOUSE;
            o_result.config_id           = n_cfg;
            o_result.intf_num            = n_mouse_intf;
            o_result.endpoint_address    = n_mouse_ep.addr;
            o_result.endpoint_max_packet = n_mouse_ep.max_packet;
            o_result.endpoint_interval   = n_mouse_ep.interval;
        end else if (n_kb_found && n_kb_ep.valid) begin
            o_result.status              = ST_KEYBOARD;
            o_result.config_id           = n_cfg;
            o_result.intf_num            = n_kb_intf;
            o_result.endpoint_address    = n_kb_ep.addr;
            o_result.endpoint_max_packet = n_kb_ep.max_packet;
            o_result.endpoint_interval   = n_kb_ep.interval;
        end else begin
            o_result.status    = (n_any_intf && n_last_hid) ? ST_HID_NOT_BOOT : ST_NO_BOOT;
            o_result.config_id = n_cfg;
        end
    end

    // parser state, cleared at reset and after the last byte of a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos         <= '0;
            r_nds         <= '0;
            r_len         <= '0;
            r_type        <= '0;
            for (int k = 0; k < FIELD_DEPTH; k++) begin
                r_fields[k] <= '0;
            end
            r_stopped     <= 1'b0;
            r_proto       <= PROTO_NONE;
            r_last_hid    <= 1'b0;
            r_any_intf    <= 1'b0;
            r_cfg         <= '0;
            r_mouse_found <= 1'b0;
            r_kb_found    <= 1'b0;
            r_mouse_intf  <= '0;
            r_kb_intf     <= '0;
            r_mouse_ep    <= '0;
            r_kb_ep       <= '0;
        end else if (i_step) begin
            r_pos         <= n_pos;
            r_nds         <= n_nds;
            r_len         <= n_len;
            r_type        <= n_type;
            r_fields      <= n_fields;
            r_stopped     <= n_stopped;
            r_proto       <= n_proto;
            r_last_hid    <= n_last_hid;
            r_any_intf    <= n_any_intf;
            r_cfg         <= n_cfg;
            r_mouse_found <= n_mouse_found;
            r_kb_found    <= n_kb_found;
            r_mouse_intf  <= n_mouse_intf;
            r_kb_intf     <= n_kb_intf;
            r_mouse_ep    <= n_mouse_ep;
            r_kb_ep       <= n_kb_ep;
        end
    end

`ifndef SYNTHESIS
    // a block end restarts the walk
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_pos == '0 && !r_stopped && r_proto == PROTO_NONE)
        else $error("parser state not cleared after block end");

    // position never runs past the cap
    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_BLOCK_BYTES))
        else $error("byte position beyond cap");

    // an endpoint is only recorded under a found boot interface
    a_mouse_ep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mouse_ep.valid |-> r_mouse_found)
        else $error("mouse endpoint without mouse interface");

    a_kb_ep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kb_ep.valid |-> r_kb_found)
        else $error("keyboard endpoint without keyboard interface");
`endif

endmodule

// ===== src/usb_hid_boot_descriptor_parser.sv =====
// top level: input register, descriptor walker and result register
// a result is valid once the last block byte has passed the input and result registers
// throughput: one descriptor byte per cycle, set by the single-pass update of the walker
// the input register stalls only when a last byte meets a result not yet taken
// reset: synchronous, active low; clears the walker and both valid flags
// the walker also returns to its reset state after each block end
module usb_hid_boot_descriptor_parser #(
    parameter int unsigned MAX_BLOCK_BYTES = uhbdp_pkg::DEFAULT_MAX_BLOCK_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    uhbdp_in_if.sink           i_byte_ch,
    uhbdp_out_if.source        o_result_ch
);
    import uhbdp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       out_free;
    logic       step;

    // pipeline control
    assign out_free        = !r_out_valid || o_result_ch.ready;
    assign step            = r_in_valid && (!r_in_last || out_free);
    assign i_byte_ch.ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_in_valid <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_ch.ready && i_byte_ch.valid) begin
            r_in_byte <= i_byte_ch.data_byte;
            r_in_last <= i_byte_ch.last_byte;
        end
    end

    uhbdp_core #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= core_result;
        end
    end

    // result transaction fields
    assign o_result_ch.valid               = r_out_valid;
    assign o_result_ch.status              = 2'(r_out.status);
    assign o_result_ch.config_id           = r_out.config_id;
    assign o_result_ch.intf_num            = r_out.intf_num;
    assign o_result_ch.endpoint_address    = r_out.endpoint_address;
    assign o_result_ch.endpoint_max_packet = r_out.endpoint_max_packet;
    assign o_result_ch.endpoint_interval   = r_out.endpoint_interval;

endmodule

// ===== tb/usb_hid_boot_descriptor_parser_test.sv =====
// self-checking testbench for the usb hid boot descriptor parser
module usb_hid_boot_descriptor_parser_test;
    import uhbdp_pkg::*;

    localparam int unsigned MAX_BYTES       = DEFAULT_MAX_BLOCK_BYTES;
    localparam int          BYTES_PER_PHASE = 400;
    localparam int          MIN_REPORTS     = 48;
    localparam int          LONG_HOLD       = 400;
    localparam int          QUIET_LIMIT     = 5000;
    localparam int          DRAIN_CYCLES    = 10;
    localparam int          MAX_REPORTED    = 10;

    // byte offsets inside a descriptor
    localparam int OFF_TYPE        = 1;
    localparam int OFF_INTF_NUM    = 2;
    localparam int OFF_CLASS       = 5;
    localparam int OFF_SUBCLASS    = 6;
    localparam int OFF_PROTOCOL    = 7;
    localparam int OFF_EP_ADDR     = 2;
    localparam int OFF_EP_ATTR     = 3;
    localparam int OFF_EP_MPS_LO   = 4;
    localparam int OFF_EP_MPS_HI   = 5;
    localparam int OFF_EP_INTERVAL = 6;

    localparam logic [7:0] DESC_TYPE_CONFIG = 8'h02;
    localparam logic [7:0] DESC_TYPE_HID    = 8'h21;

    // tracks the parse of each block and checks the reported boot device
    class boot_hid_scoreboard;
        logic [8:0]  byte_pos;
        logic [8:0]  next_start;
        logic [7:0]  desc_len;
        logic [7:0]  desc_kind;
        logic [7:0]  desc_bytes [FIELD_DEPTH];
        logic        walk_stopped;
        t_proto      boot_proto;
        logic        last_was_hid;
        logic        saw_interface;
        logic [7:0]  cfg_value;
        logic        mouse_seen;
        logic        keyboard_seen;
        logic [7:0]  mouse_intf;
        logic [7:0]  keyboard_intf;
        t_ep_rec     mouse_ep;
        t_ep_rec     keyboard_ep;
        t_result     pending_reports [$];
        int          report_count;
        int          checked_count;
        int          mismatch_count;

        function new();
            report_count   = 0;
            checked_count  = 0;
            mismatch_count = 0;
            restart();
        endfunction

        function void restart();
            byte_pos      = '0;
            next_start    = '0;
            desc_len      = '0;
            desc_kind     = '0;
            desc_bytes    = '{default: '0};
            walk_stopped  = 1'b0;
            boot_proto    = PROTO_NONE;
            last_was_hid  = 1'b0;
            saw_interface = 1'b0;
            cfg_value     = '0;
            mouse_seen    = 1'b0;
            keyboard_seen = 1'b0;
            mouse_intf    = '0;
            keyboard_intf = '0;
            mouse_ep      = '0;
            keyboard_ep   = '0;
        endfunction

        // act on a descriptor whose last byte has just arrived
        function void close_descriptor();
            t_ep_rec rec;
            if (desc_kind == DESC_TYPE_INTERFACE && desc_len >= INTF_MIN_LEN) begin
                saw_interface = 1'b1;
                last_was_hid  = (desc_bytes[OFF_CLASS] == CLASS_HID);
                if (desc_bytes[OFF_CLASS] == CLASS_HID && desc_bytes[OFF_SUBCLASS] == SUBCLASS_BOOT
                        && desc_bytes[OFF_PROTOCOL] == PROTOCOL_MOUSE) begin
                    mouse_seen = 1'b1;
                    boot_proto = PROTO_MOUSE;
                    mouse_intf = desc_bytes[OFF_INTF_NUM];
                end else if (desc_bytes[OFF_CLASS] == CLASS_HID
                        && desc_bytes[OFF_SUBCLASS] == SUBCLASS_BOOT
                        && desc_bytes[OFF_PROTOCOL] == PROTOCOL_KEYBOARD) begin
                    keyboard_seen = 1'b1;
                    boot_proto    = PROTO_KEYBOARD;
                    keyboard_intf = desc_bytes[OFF_INTF_NUM];
                end else begin
                    boot_proto = PROTO_NONE;
                end
            end
            if (desc_kind == DESC_TYPE_ENDPOINT && desc_len >= EP_MIN_LEN
                    && boot_proto != PROTO_NONE) begin
                if ((desc_bytes[OFF_EP_ADDR] & EP_DIR_IN) != 8'd0
                        && (desc_bytes[OFF_EP_ATTR] & EP_XFER_MASK) == EP_XFER_INTERRUPT) begin
                    rec.addr       = desc_bytes[OFF_EP_ADDR];
                    rec.max_packet = {desc_bytes[OFF_EP_MPS_HI], desc_bytes[OFF_EP_MPS_LO]};
                    rec.interval   = desc_bytes[OFF_EP_INTERVAL];
                    rec.valid      = 1'b1;
                    if (boot_proto == PROTO_MOUSE)
                        mouse_ep = rec;
                    else
                        keyboard_ep = rec;
                end
            end
        endfunction

        // one kept byte of the descriptor chain walk
        function void walk_byte(logic [8:0] pos, logic [7:0] b);
            int offset;
            if (pos == HEADER_CFG_POS)
                cfg_value = b;
            if (walk_stopped)
                return;
            if (pos == 0) begin
                if (b == 8'd0)
                    walk_stopped = 1'b1;
                else
                    next_start = {1'b0, b};
                return;
            end
            if (pos < next_start)
                return;
            if (pos == next_start) begin
                if (b == 8'd0) begin
                    walk_stopped = 1'b1;
                    return;
                end
                desc_len      = b;
                desc_kind     = '0;
                desc_bytes    = '{default: '0};
                desc_bytes[0] = b;
                if (b == 8'd1)
                    next_start = pos + 9'd1;
                return;
            end
            offset = int'(pos) - int'(next_start);
            if (offset < FIELD_DEPTH)
                desc_bytes[offset] = b;
            if (offset == OFF_TYPE)
                desc_kind = b;
            if (offset + 1 >= int'(desc_len)) begin
                close_descriptor();
                next_start = pos + 9'd1;
            end
        endfunction

        // accepted input transaction
        function void note_byte(logic [7:0] b, logic last);
            t_result rpt;
            if (byte_pos < MAX_BYTES) begin
                walk_byte(byte_pos, b);
                byte_pos = byte_pos + 9'd1;
            end
            if (!last)
                return;
            rpt = '0;
            rpt.config_id = cfg_value;
            if (byte_pos < MIN_BLOCK_BYTES) begin
                rpt.status    = ST_NO_BOOT;
                rpt.config_id = '0;
            end else if (mouse_seen && mouse_ep.valid) begin
                rpt.status              = ST_MOUSE;
                rpt.intf_num            = mouse_intf;
                rpt.endpoint_address    = mouse_ep.addr;
                rpt.endpoint_max_packet = mouse_ep.max_packet;
                rpt.endpoint_interval   = mouse_ep.interval;
            end else if (keyboard_seen && keyboard_ep.valid) begin
                rpt.status              = ST_KEYBOARD;
                rpt.intf_num            = keyboard_intf;
                rpt.endpoint_address    = keyboard_ep.addr;
                rpt.endpoint_max_packet = keyboard_ep.max_packet;
                rpt.endpoint_interval   = keyboard_ep.interval;
            end else begin
                rpt.status = (saw_interface && last_was_hid) ? ST_HID_NOT_BOOT : ST_NO_BOOT;
            end
            pending_reports.push_back(rpt);
            report_count++;
            restart();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("result %0d: %s expected 0x%0h, got 0x%0h",
                             checked_count, name, want, got);
            end
        endfunction

        // accepted result transaction
        function void check_result(t_result got);
            t_result want;
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("unexpected result: status %0d config 0x%0h",
                             got.status, got.config_id);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("config_id", want.config_id, got.config_id);
            compare_field("intf_num", want.intf_num, got.intf_num);
            compare_field("endpoint_address", want.endpoint_address, got.endpoint_address);
            compare_field("endpoint_max_packet", want.endpoint_max_packet,
                          got.endpoint_max_packet);
            compare_field("endpoint_interval", want.endpoint_interval, got.endpoint_interval);
            checked_count++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    uhbdp_in_if  byte_ch ();
    uhbdp_out_if result_ch ();

    boot_hid_scoreboard sb = new();

    logic [7:0] blk [$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_left = 0;
    int         quiet_cycles;

    usb_hid_boot_descriptor_parser #(
        .MAX_BLOCK_BYTES (MAX_BYTES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .o_result_ch (result_ch)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready = 1'b0;
                hold_left--;
            end else begin
                result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.status              = t_status'(result_ch.status);
            got.config_id           = result_ch.config_id;
            got.intf_num            = result_ch.intf_num;
            got.endpoint_address    = result_ch.endpoint_address;
            got.endpoint_max_packet = result_ch.endpoint_max_packet;
            got.endpoint_interval   = result_ch.endpoint_interval;
            sb.check_result(got);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (byte_ch.valid && byte_ch.ready)
                    || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // offer one byte and hold it until the transaction happens
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.last_byte = last;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        sb.note_byte(b, last);
        @(negedge i_clk);
        byte_ch.valid = 1'b0;
    endtask

    task automatic send_block();
        foreach (blk[i])
            send_byte(blk[i], i == blk.size() - 1);
    endtask

    task automatic wait_drained();
        while (sb.pending_reports.size() != 0)
            @(negedge i_clk);
    endtask

    // descriptor of a given type with random body
    function automatic void push_plain(logic [7:0] kind, int len);
        blk.push_back(8'(len));
        blk.push_back(kind);
        for (int k = OFF_TYPE + 1; k < len; k++)
            blk.push_back(8'($urandom));
    endfunction

    // interface descriptor, mostly boot hid, sometimes short or long
    function automatic void push_interface();
        int         len;
        int         roll;
        logic [7:0] v;
        roll = $urandom_range(99);
        if (roll < 75)
            len = INTF_MIN_LEN;
        else if (roll < 85)
            len = $urandom_range(14, INTF_MIN_LEN + 1);
        else
            len = $urandom_range(INTF_MIN_LEN - 1, 2);
        blk.push_back(8'(len));
        blk.push_back(DESC_TYPE_INTERFACE);
        for (int k = OFF_TYPE + 1; k < len; k++) begin
            v = 8'($urandom);
            if (k == OFF_CLASS && $urandom_range(99) < 85)
                v = CLASS_HID;
            if (k == OFF_SUBCLASS && $urandom_range(99) < 85)
                v = SUBCLASS_BOOT;
            if (k == OFF_PROTOCOL) begin
                roll = $urandom_range(99);
                if (roll < 40)
                    v = PROTOCOL_MOUSE;
                else if (roll < 80)
                    v = PROTOCOL_KEYBOARD;
            end
            blk.push_back(v);
        end
    endfunction

    // endpoint descriptor, mostly interrupt in
    function automatic void push_endpoint();
        int         len;
        int         roll;
        logic [7:0] v;
        roll = $urandom_range(99);
        if (roll < 75)
            len = EP_MIN_LEN;
        else if (roll < 85)
            len = $urandom_range(10, EP_MIN_LEN + 1);
        else
            len = $urandom_range(EP_MIN_LEN - 1, 2);
        blk.push_back(8'(len));
        blk.push_back(DESC_TYPE_ENDPOINT);
        for (int k = OFF_TYPE + 1; k < len; k++) begin
            v = 8'($urandom);
            if (k == OFF_EP_ADDR && $urandom_range(99) < 85)
                v = v | EP_DIR_IN;
            if (k == OFF_EP_ATTR && $urandom_range(99) < 80)
                v = v | EP_XFER_INTERRUPT;
            blk.push_back(v);
        end
    endfunction

    // random configuration block: mostly well formed chains, some broken ones
    function automatic void make_block();
        int hdr_len;
        int roll;
        int cut;
        blk.delete();
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(MIN_BLOCK_BYTES - 1, 1))
                blk.push_back(8'($urandom));
            return;
        end
        roll = $urandom_range(99);
        if (roll < 80)
            hdr_len = MIN_BLOCK_BYTES;
        else if (roll < 88)
            hdr_len = 0;
        else if (roll < 95)
            hdr_len = $urandom_range(MIN_BLOCK_BYTES - 1, 1);
        else
            hdr_len = $urandom_range(16, MIN_BLOCK_BYTES + 1);
        blk.push_back(8'(hdr_len));
        blk.push_back($urandom_range(99) < 90 ? DESC_TYPE_CONFIG : 8'($urandom));
        repeat (MIN_BLOCK_BYTES - 2)
            blk.push_back(8'($urandom));
        for (int k = MIN_BLOCK_BYTES; k < hdr_len; k++)
            blk.push_back(8'($urandom));
        repeat ($urandom_range(7, 1)) begin
            roll = $urandom_range(99);
            if (roll < 35)
                push_interface();
            else if (roll < 75)
                push_endpoint();
            else if (roll < 85)
                push_plain(DESC_TYPE_HID, INTF_MIN_LEN);
            else if (roll < 90)
                blk.push_back(8'd1);
            else if (roll < 93)
                blk.push_back(8'd0);
            else
                push_plain(8'($urandom), $urandom_range(12, 2));
        end
        // cut the block short, or run it past the byte cap
        roll = $urandom_range(99);
        if (roll < 10) begin
            cut = $urandom_range(blk.size(), 1);
            while (blk.size() > cut)
                void'(blk.pop_back());
        end else if (roll < 13) begin
            cut = $urandom_range(MAX_BYTES + 40, MAX_BYTES + 1);
            while (blk.size() < cut)
                blk.push_back(8'($urandom));
        end
    endfunction

    // main sequence
    initial begin
        int phase_bytes;
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // one-byte block
        blk = '{8'h00};
        send_block();
        // boot mouse with interrupt in endpoint
        blk = '{8'd9, DESC_TYPE_CONFIG, 8'd25, 8'd0, 8'd1, 8'h5A, 8'd1, 8'hA0, 8'd50,
                8'd9, DESC_TYPE_INTERFACE, 8'd0, 8'd0, 8'd1,
                CLASS_HID, SUBCLASS_BOOT, PROTOCOL_MOUSE, 8'd0,
                8'd7, DESC_TYPE_ENDPOINT, 8'h81, EP_XFER_INTERRUPT, 8'd8, 8'd0, 8'd10};
        send_block();
        // boot keyboard with all-ones fields
        blk = '{8'd9, DESC_TYPE_CONFIG, 8'd25, 8'd0, 8'd1, 8'hFF, 8'd0, 8'hFF, 8'hFF,
                8'd9, DESC_TYPE_INTERFACE, 8'hFF, 8'd0, 8'd1,
                CLASS_HID, SUBCLASS_BOOT, PROTOCOL_KEYBOARD, 8'hFF,
                8'd7, DESC_TYPE_ENDPOINT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_block();
        // zero header length stops the walk
        blk = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hA5, 8'd0, 8'd0, 8'd0};
        send_block();
        wait_drained();

        // long receiver hold-off while short blocks keep coming
        hold_left = LONG_HOLD;
        repeat (8) begin
            blk.delete();
            repeat ($urandom_range(3, 1))
                blk.push_back(8'($urandom));
            send_block();
        end
        wait_drained();

        // random blocks under each idling mix
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE
                    || (phase == 3 && sb.report_count < MIN_REPORTS)) begin
                make_block();
                send_block();
                phase_bytes += blk.size();
            end
            byte_ch.valid = 1'b0;
            wait_drained();
        end

        // let any stray result show up
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/uhbdp_pkg.sv
src/uhbdp_in_if.sv
src/uhbdp_out_if.sv
src/uhbdp_core.sv
src/usb_hid_boot_descriptor_parser.sv
tb/usb_hid_boot_descriptor_parser_test.sv
